// ----- rtl/core/control_word_scale_and_segment_encode_core_defines.svh -----
// Assertion macros shared by the checker of the control word scale core.
// Depends on nothing; included by the checker file.
`ifndef CONTROL_WORD_SCALE_AND_SEGMENT_ENCODE_CORE_DEFINES_SVH
`define CONTROL_WORD_SCALE_AND_SEGMENT_ENCODE_CORE_DEFINES_SVH

// Implication checked at every clock edge, idle during reset.
`define CWS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked at every clock edge, idle during reset.
`define CWS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/cws_pkg.sv -----
// Package of the control word scale and segment encode core.
// Holds widths, the cell payload type and the segment code tables; no dependencies.
`timescale 1ns / 1ps
package cws_pkg;
	localparam int unsigned NumCells = 14;
	localparam logic [9:0] AmpMax = 10'd999;
	localparam logic [13:0] FreqMax = 14'd9999;
	localparam logic [7:0] DpMask = 8'h7f;

	// Item state that travels down the row of cells.
	typedef struct packed {
		logic        vld;
		logic [1:0]  wave;
		logic [5:0]  adiv_m1;
		logic [4:0]  ffac_m1;
		logic        down;
		logic [13:0] arem;   // amplitude dividend shifting out, MSB first
		logic [5:0]  ares;   // amplitude partial remainder
		logic [9:0]  aquo;
		logic [13:0] fdvd;   // frequency dividend, or multiplicand when multiplying
		logic [18:0] facc;   // remainder when dividing, product when multiplying
		logic [13:0] fquo;   // quotient when dividing, factor shifting out when multiplying
	} cell_t;

	function automatic logic [7:0] digit_seg(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'hc0;
			4'd1: s = 8'hf9;
			4'd2: s = 8'ha4;
			4'd3: s = 8'hb0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hf8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = 8'hff;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] wave_seg(input logic [1:0] w);
		logic [7:0] s;
		case (w)
			2'd0: s = 8'ha0;
			2'd1: s = 8'h83;
			2'd2: s = 8'hc6;
			2'd3: s = 8'ha1;
			default: s = 8'hff;
		endcase
		return s;
	endfunction
endpackage

// ----- rtl/core/control_word_scale_and_segment_encode_core.sv -----
// Top level of the control word scale and segment encode core.
// Depends on cws_pkg, cws_cell and cws_digits.
//
// Usage: drive control_word, amplitude_base and frequency_base and raise start;
// the item is accepted at any rising edge where start is high and busy is low.
// busy is tied low: the core is a fourteen-cell pipeline and takes a new item
// every cycle, with any number of items in flight.
// Each cell performs one restoring-division bit for the amplitude (divisor up
// to 64) and one bit of the frequency division, or, when multiplying, one
// shift-add step over the six-bit factor.
// Two output stages saturate, split decimal digits and encode segments.
// done rises once the item has passed the fourteen cells and the two output
// stages; throughput is one item per cycle. done is high for exactly one cycle
// with all result ports valid; the receiver cannot stall, so it must capture
// them then.
// Reset (arst_n low) clears the cell row and all valid bits, so no stray done
// appears; the output payload registers are not reset.
`timescale 1ns / 1ps
module control_word_scale_and_segment_encode_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] control_word,
	input  logic [9:0]  amplitude_base,
	input  logic [13:0] frequency_base,
	output logic        done,
	output logic [9:0]  amplitude_scaled,
	output logic [13:0] frequency_scaled,
	output logic [7:0]  seg_wave,
	output logic [7:0]  seg_amp_hundreds,
	output logic [7:0]  seg_amp_tens,
	output logic [7:0]  seg_amp_units,
	output logic [7:0]  seg_freq_thousands,
	output logic [7:0]  seg_freq_hundreds,
	output logic [7:0]  seg_freq_tens,
	output logic [7:0]  seg_freq_units
);
	import cws_pkg::*;

	cell_t head;
	cell_t row [NumCells+1];

	assign busy = 1'b0;
	assign row[0] = head;

	// The amplitude is right-aligned in the 14-bit dividend field so both
	// divisions finish in the same fourteen steps; the leading zeros give zero
	// quotient bits. For multiply, fquo carries the full factor right-aligned
	// and the cells consume it MSB first.
	always_comb begin
		head = '0;
		head.vld = start;
		head.wave = control_word[1:0];
		head.adiv_m1 = control_word[7:2];
		head.ffac_m1 = control_word[12:8];
		head.down = control_word[13];
		head.arem = {4'd0, amplitude_base};
		head.fdvd = frequency_base;
		if (!control_word[13]) begin
			head.fquo = {8'd0, {1'b0, control_word[12:8]} + 6'd1};
		end
	end

	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		cws_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.d(row[i]),
			.q(row[i+1])
		);
	end

	cws_digits u_digits (
		.clk(clk),
		.arst_n(arst_n),
		.d(row[NumCells]),
		.done(done),
		.amplitude_scaled(amplitude_scaled),
		.frequency_scaled(frequency_scaled),
		.seg_wave(seg_wave),
		.seg_amp_hundreds(seg_amp_hundreds),
		.seg_amp_tens(seg_amp_tens),
		.seg_amp_units(seg_amp_units),
		.seg_freq_thousands(seg_freq_thousands),
		.seg_freq_hundreds(seg_freq_hundreds),
		.seg_freq_tens(seg_freq_tens),
		.seg_freq_units(seg_freq_units)
	);
endmodule

// ----- rtl/core/cws_cell.sv -----
// One step cell: one restoring division bit for amplitude and frequency,
// or one shift-add multiply bit for frequency. Uses cws_pkg.
`timescale 1ns / 1ps
module cws_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  cws_pkg::cell_t d,
	output cws_pkg::cell_t q
);
	import cws_pkg::*;

	logic [6:0] a_try;
	logic [6:0] a_div;
	logic [5:0] f_try;
	logic [5:0] f_div;
	cell_t      nxt;

	always_comb begin
		nxt = d;
		// Amplitude: the next dividend bit joins the partial remainder.
		a_div = {1'b0, d.adiv_m1} + 7'd1;
		a_try = {d.ares, d.arem[13]};
		nxt.arem = {d.arem[12:0], 1'b0};
		if (a_try >= a_div) begin
			nxt.ares = 6'(a_try - a_div);
			nxt.aquo = {d.aquo[8:0], 1'b1};
		end else begin
			nxt.ares = a_try[5:0];
			nxt.aquo = {d.aquo[8:0], 1'b0};
		end
		f_div = {1'b0, d.ffac_m1} + 6'd1;
		f_try = {d.facc[4:0], d.fdvd[13]};
		if (d.down) begin
			nxt.fdvd = {d.fdvd[12:0], 1'b0};
			if (f_try >= f_div) begin
				nxt.fquo = {d.fquo[12:0], 1'b1};
				nxt.facc = {14'd0, 5'(f_try - f_div)};
			end else begin
				nxt.fquo = {d.fquo[12:0], 1'b0};
				nxt.facc = {14'd0, f_try[4:0]};
			end
		end else begin
			// Multiply: factor bits leave fquo MSB first; leading zero bits leave facc at zero.
			nxt.facc = {d.facc[17:0], 1'b0} + (d.fquo[13] ? {5'd0, d.fdvd} : 19'd0);
			nxt.fquo = {d.fquo[12:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else begin
			q <= nxt;
		end
	end
endmodule

// ----- rtl/core/cws_digits.sv -----
// Output stage: saturation, decimal digit split and segment encoding.
// Uses cws_pkg; fed by the last cell of the row.
`timescale 1ns / 1ps
module cws_digits (
	input  logic           clk,
	input  logic           arst_n,
	input  cws_pkg::cell_t d,
	output logic           done,
	output logic [9:0]     amplitude_scaled,
	output logic [13:0]    frequency_scaled,
	output logic [7:0]     seg_wave,
	output logic [7:0]     seg_amp_hundreds,
	output logic [7:0]     seg_amp_tens,
	output logic [7:0]     seg_amp_units,
	output logic [7:0]     seg_freq_thousands,
	output logic [7:0]     seg_freq_hundreds,
	output logic [7:0]     seg_freq_tens,
	output logic [7:0]     seg_freq_units
);
	import cws_pkg::*;

	logic [9:0]  amp_sat;
	logic [13:0] frq_sat;
	logic [18:0] frq_raw;
	logic        vld_s1;
	logic [1:0]  wave_s1;
	logic [9:0]  amp_s1;
	logic [13:0] frq_s1;
	logic [3:0]  a_h, a_t, a_u, f_th, f_h, f_t, f_u;
	logic [15:0] a_m100;
	logic [17:0] a_m10;
	logic [6:0]  a_q10;
	logic [26:0] f_m1000;
	logic [26:0] f_m100;
	logic [26:0] f_m10;
	logic [6:0]  f_q100;
	logic [9:0]  f_q10;

	always_comb begin
		amp_sat = (d.aquo > AmpMax) ? AmpMax : d.aquo;
		frq_raw = d.down ? {5'd0, d.fquo} : d.facc;
		frq_sat = (frq_raw > 19'(FreqMax)) ? FreqMax : frq_raw[13:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1 <= d.vld;
			done <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		wave_s1 <= d.wave;
		amp_s1 <= amp_sat;
		frq_s1 <= frq_sat;
	end

	// Reciprocal multiplications give the quotients by 10, 100 and 1000 in parallel;
	// they are exact over the saturated ranges (up to 999 and 9999).
	always_comb begin
		a_m100 = 16'(amp_s1) * 16'd41;
		a_m10 = 18'(amp_s1) * 18'd205;
		a_h = a_m100[15:12];
		a_q10 = a_m10[17:11];
		a_t = 4'(a_q10 - {3'd0, a_h} * 7'd10);
		a_u = 4'(amp_s1 - {3'd0, a_q10} * 10'd10);
		f_m1000 = 27'(frq_s1) * 27'd8389;
		f_m100 = 27'(frq_s1) * 27'd5243;
		f_m10 = 27'(frq_s1) * 27'd6554;
		f_th = f_m1000[26:23];
		f_q100 = f_m100[25:19];
		f_q10 = f_m10[25:16];
		f_h = 4'(f_q100 - {3'd0, f_th} * 7'd10);
		f_t = 4'(f_q10 - {3'd0, f_q100} * 10'd10);
		f_u = 4'(frq_s1 - {4'd0, f_q10} * 14'd10);
	end

	always_ff @(posedge clk) begin
		amplitude_scaled <= amp_s1;
		frequency_scaled <= frq_s1;
		seg_wave <= wave_seg(wave_s1);
		seg_amp_hundreds <= digit_seg(a_h) & DpMask;
		seg_amp_tens <= digit_seg(a_t);
		seg_amp_units <= digit_seg(a_u);
		seg_freq_thousands <= digit_seg(f_th);
		seg_freq_hundreds <= digit_seg(f_h);
		seg_freq_tens <= digit_seg(f_t);
		seg_freq_units <= digit_seg(f_u);
	end
endmodule

// ----- rtl/core/cws_checker.sv -----
// Port-level checker for the control word scale core, bound to the top level.
// Depends on the defines header.
`timescale 1ns / 1ps
`include "control_word_scale_and_segment_encode_core_defines.svh"
module cws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        done,
	input logic [9:0]  amplitude_scaled,
	input logic [13:0] frequency_scaled,
	input logic [7:0]  seg_amp_hundreds
);
	`CWS_ASSERT_IMP(a_never_busy, clk, arst_n, 1'b1, !busy, "core reported busy")
	`CWS_ASSERT_IMP(a_amp_range, clk, arst_n, done, amplitude_scaled <= 10'd999, "amp above 999")
	`CWS_ASSERT_IMP(a_frq_range, clk, arst_n, done, frequency_scaled <= 14'd9999, "freq above 9999")
	`CWS_ASSERT_IMP(a_dp_lit, clk, arst_n, done, !seg_amp_hundreds[7], "decimal point not lit")
endmodule

bind control_word_scale_and_segment_encode_core cws_checker u_cws_checker (
	.clk(clk),
	.arst_n(arst_n),
	.busy(busy),
	.done(done),
	.amplitude_scaled(amplitude_scaled),
	.frequency_scaled(frequency_scaled),
	.seg_amp_hundreds(seg_amp_hundreds)
);

// ----- tb/tb.sv -----
// Testbench of the control word scale and segment encode core.
// Depends on cws_pkg and control_word_scale_and_segment_encode_core; self-checking.
`timescale 1ns / 1ps

// Expected results of the scaler, kept oldest first.
class scale_scoreboard;
	typedef struct packed {
		logic [9:0]  amp;
		logic [13:0] frq;
		logic [7:0]  wave;
		logic [7:0]  ah, at, au;
		logic [7:0]  ft, fh, fte, fu;
	} scaled_t;

	scaled_t pending[$];
	int      errors;
	int      checked;

	function logic [7:0] digit_code(input int d);
		logic [7:0] codes[10];
		codes = '{8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90};
		return codes[d % 10];
	endfunction

	// Works out the scaled values and their digit codes for one accepted item.
	function void note_item(input logic [15:0] ctl, input logic [9:0] ab,
			input logic [13:0] fb);
		int      amp, frq, adiv, ffac;
		scaled_t e;
		logic [7:0] waves[4];
		waves = '{8'ha0, 8'h83, 8'hc6, 8'ha1};
		adiv = int'(ctl[7:2]) + 1;
		ffac = int'(ctl[12:8]) + 1;
		amp = int'(ab) / adiv;
		if (amp > 999) amp = 999;
		frq = ctl[13] ? int'(fb) / ffac : int'(fb) * ffac;
		if (frq > 9999) frq = 9999;
		e.amp = amp[9:0];
		e.frq = frq[13:0];
		e.wave = waves[ctl[1:0]];
		e.ah = digit_code(amp / 100) & 8'h7f;
		e.at = digit_code(amp / 10);
		e.au = digit_code(amp);
		e.ft = digit_code(frq / 1000);
		e.fh = digit_code(frq / 100);
		e.fte = digit_code(frq / 10);
		e.fu = digit_code(frq);
		pending.push_back(e);
	endfunction

	task report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("MISMATCH %s: got %0h, expected %0h (result %0d)", what, got, want, checked);
		errors++;
	endtask

	task check_result(input scaled_t got);
		scaled_t w;
		if (pending.size() == 0) begin
			report("unexpected result", 1, 0);
			return;
		end
		w = pending.pop_front();
		if (got.amp !== w.amp) report("amplitude_scaled", got.amp, w.amp);
		if (got.frq !== w.frq) report("frequency_scaled", got.frq, w.frq);
		if (got.wave !== w.wave) report("seg_wave", got.wave, w.wave);
		if (got.ah !== w.ah) report("seg_amp_hundreds", got.ah, w.ah);
		if (got.at !== w.at) report("seg_amp_tens", got.at, w.at);
		if (got.au !== w.au) report("seg_amp_units", got.au, w.au);
		if (got.ft !== w.ft) report("seg_freq_thousands", got.ft, w.ft);
		if (got.fh !== w.fh) report("seg_freq_hundreds", got.fh, w.fh);
		if (got.fte !== w.fte) report("seg_freq_tens", got.fte, w.fte);
		if (got.fu !== w.fu) report("seg_freq_units", got.fu, w.fu);
		checked++;
	endtask
endclass

module tb;
	import cws_pkg::*;

	localparam int Latency = 16;
	localparam int CycleLimit = 200000;

	logic        clk, arst_n, start, busy, done;
	logic [15:0] control_word;
	logic [9:0]  amplitude_base, amplitude_scaled;
	logic [13:0] frequency_base, frequency_scaled;
	logic [7:0]  seg_wave, seg_amp_hundreds, seg_amp_tens, seg_amp_units;
	logic [7:0]  seg_freq_thousands, seg_freq_hundreds, seg_freq_tens, seg_freq_units;

	scale_scoreboard sb;
	int cycles;
	int sent;

	control_word_scale_and_segment_encode_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: the slowest correct run is far below this limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// Sampling at the rising edge: the input side notes accepted items and the
	// output side checks each strobed result. The core cannot be stalled, so
	// every done cycle must be captured right here.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_item(control_word, amplitude_base, frequency_base);
		if (arst_n && done)
			sb.check_result({amplitude_scaled, frequency_scaled, seg_wave,
				seg_amp_hundreds, seg_amp_tens, seg_amp_units, seg_freq_thousands,
				seg_freq_hundreds, seg_freq_tens, seg_freq_units});
	end

	// Presents one item from the falling edge and holds it until accepted.
	// start is left high so back-to-back items see no dip.
	task automatic send_item(input logic [15:0] ctl, input logic [9:0] ab,
			input logic [13:0] fb);
		@(negedge clk);
		start <= 1'b1;
		control_word <= ctl;
		amplitude_base <= ab;
		frequency_base <= fb;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic idle_gap(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			control_word <= 16'($urandom);
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Mostly in-range base values and small factors in a third of items, with full-range
	// noise mixed in so every field bit toggles, saturation is hit and bits 15:14 wiggle.
	task automatic send_random();
		logic [15:0] ctl;
		logic [9:0]  ab;
		logic [13:0] fb;
		ctl = 16'($urandom);
		ab = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 999));
		fb = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 9999));
		if ($urandom_range(0, 2) == 0) ctl[12:8] = 5'($urandom_range(0, 3));
		send_item(ctl, ab, fb);
	endtask

	initial begin
		int burst;
		sb = new();
		cycles = 0;
		sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		control_word = '0;
		amplitude_base = '0;
		frequency_base = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, every waveform letter, both frequency
		// directions, saturation of both values, ignored top control bits.
		send_item(16'h0000, 10'd0, 14'd0);
		send_item(16'h0001, 10'd999, 14'd9999);
		send_item(16'h0002, 10'd1023, 14'd16383);
		send_item(16'h0003, 10'd1000, 14'd10000);
		send_item(16'h00fc, 10'd1023, 14'd9999);
		send_item(16'h00fc, 10'd63, 14'd1);
		send_item(16'h1f00, 10'd500, 14'd312);
		send_item(16'h1f00, 10'd500, 14'd313);
		send_item(16'h3f00, 10'd10, 14'd16383);
		send_item(16'h3f00, 10'd10, 14'd31);
		send_item(16'h2000, 10'd123, 14'd4567);
		send_item(16'hc000, 10'd456, 14'd8901);
		send_item(16'hffff, 10'd1023, 14'd16383);
		send_item(16'h0100, 10'd5, 14'd5000);
		send_item(16'h0100, 10'd5, 14'd4999);
		send_item(16'h2004, 10'd1023, 14'd1);
		send_item(16'h0004, 10'd1, 14'd0);
		send_item(16'h5555, 10'h2aa, 14'h2aaa);
		send_item(16'haaaa, 10'h155, 14'h1555);
		idle_gap(1);

		// Random bursts with random gaps, plus stretches with no gaps at all.
		while (sent < 830) begin
			burst = $urandom_range(1, 40);
			repeat (burst) send_random();
			if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 20));
			if (sent > 400 && sent < 450) begin
				// Hold off until the pipeline has drained completely.
				idle_gap(1);
				while (sb.pending.size() != 0) @(posedge clk);
			end
		end
		idle_gap(1);

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);

		$display("Sent %0d items over %0d cycles; %0d results checked.", sent, cycles,
			sb.checked);
		$display("Covered all waveforms, both frequency directions and saturation.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
